[rtl/baro_temp_compensation_top_assert.svh]
// assertion macros for the compensation block
`ifndef BARO_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define BARO_TEMP_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define BARO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BARO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/baro_pkg.sv]
// shared types, constants and arithmetic helpers for the compensation block
`default_nettype none
package baro_pkg;

  localparam int unsigned DIV_STAGES = 32;
  localparam logic [31:0] FINE_OFS   = 32'd64000;
  localparam logic [31:0] PRESS_BASE = 32'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [31:0] P1_OFS     = 32'd32768;
  localparam logic [31:0] T_ROUND    = 32'd128;

  typedef enum logic [1:0] {
    REG_TEMP_CAL    = 2'd0,
    REG_PRESS_CAL_A = 2'd1,
    REG_PRESS_CAL_B = 2'd2,
    REG_PRESS_CAL_C = 2'd3
  } baro_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } baro_cal_t;

  typedef struct packed {
    logic [31:0] temp;
    logic        dbl;
    logic        zero;
  } baro_side_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    baro_side_t  side;
  } baro_div_in_t;

  typedef struct packed {
    logic [31:0] quo;
    baro_side_t  side;
  } baro_div_out_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

[rtl/baro_front.sv]
// temperature path and pressure divisor / dividend pipeline
`default_nettype none
module baro_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_beat,
  input  wire logic [19:0]         raw_t,
  input  wire logic [19:0]         raw_p,
  input  wire baro_pkg::baro_cal_t cal,
  output logic                     out_vld,
  output baro_pkg::baro_div_in_t   out_data
);

  logic [10:0] vld;

  logic [31:0] a1, d1;
  logic [19:0] up1, up2, up3, up4, up5, up6, up7, up8, up9;
  logic [31:0] m1_2, dd2;
  logic [31:0] x1_3, m2_3;
  logic [31:0] fine4;
  logic [31:0] temp5, temp6, temp7, temp8, temp9, temp10, temp11;
  logic [31:0] px1_5, q5;
  logic [31:0] qq6, m5_6, m2b6;
  logic [31:0] x2a7, m3_7, m5_7, m2b7;
  logic [31:0] x2b8, x1b8;
  logic [31:0] x2c9, x1c9;
  logic [31:0] den10, pn10, den11;
  logic [31:0] p11;
  logic [31:0] px1_c;

  assign px1_c = baro_pkg::asr32(fine4, 1) - baro_pkg::FINE_OFS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_beat};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= 32'(raw_t >> 3) - {15'd0, cal.t1, 1'b0};
      d1    <= 32'(raw_t >> 4) - {16'd0, cal.t1};
      up1   <= raw_p;

      m1_2  <= a1 * baro_pkg::sx16(cal.t2);
      dd2   <= d1 * d1;
      up2   <= up1;

      x1_3  <= baro_pkg::asr32(m1_2, 11);
      m2_3  <= baro_pkg::asr32(dd2, 12) * baro_pkg::sx16(cal.t3);
      up3   <= up2;

      fine4 <= x1_3 + baro_pkg::asr32(m2_3, 14);
      up4   <= up3;

      temp5 <= baro_pkg::asr32((fine4 << 2) + fine4 + baro_pkg::T_ROUND, 8);
      px1_5 <= px1_c;
      q5    <= baro_pkg::asr32(px1_c, 2);
      up5   <= up4;

      qq6   <= q5 * q5;
      m5_6  <= px1_5 * baro_pkg::sx16(cal.p5);
      m2b6  <= baro_pkg::sx16(cal.p2) * px1_5;
      temp6 <= temp5;
      up6   <= up5;

      x2a7  <= baro_pkg::asr32(qq6, 11) * baro_pkg::sx16(cal.p6);
      m3_7  <= baro_pkg::sx16(cal.p3) * baro_pkg::asr32(qq6, 13);
      m5_7  <= m5_6;
      m2b7  <= m2b6;
      temp7 <= temp6;
      up7   <= up6;

      x2b8  <= x2a7 + (m5_7 << 1);
      x1b8  <= baro_pkg::asr32(baro_pkg::asr32(m3_7, 3) + baro_pkg::asr32(m2b7, 1), 18);
      temp8 <= temp7;
      up8   <= up7;

      x2c9  <= baro_pkg::asr32(x2b8, 2) + {cal.p4, 16'd0};
      x1c9  <= (baro_pkg::P1_OFS + x1b8) * {16'd0, cal.p1};
      temp9 <= temp8;
      up9   <= up8;

      den10  <= baro_pkg::asr32(x1c9, 15);
      pn10   <= (baro_pkg::PRESS_BASE - {12'd0, up9}) - baro_pkg::asr32(x2c9, 12);
      temp10 <= temp9;

      p11    <= pn10 * baro_pkg::P_SCALE;
      den11  <= den10;
      temp11 <= temp10;
    end
  end

  // large dividends are divided first and doubled afterwards
  always_comb begin
    out_data.num       = p11[31] ? p11 : (p11 << 1);
    out_data.den       = den11;
    out_data.side.temp = temp11;
    out_data.side.dbl  = p11[31];
    out_data.side.zero = (den11 == 32'd0);
  end

  assign out_vld = vld[10];

endmodule
`default_nettype wire

[rtl/baro_div.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
`include "baro_temp_compensation_top_assert.svh"
module baro_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire baro_pkg::baro_div_in_t in_data,
  output logic                        out_vld,
  output baro_pkg::baro_div_out_t     out_data
);

  localparam int unsigned N = baro_pkg::DIV_STAGES;

  logic [N-1:0]         vld;
  logic [31:0]          rem  [N];
  logic [31:0]          nrm  [N];
  logic [31:0]          den  [N];
  logic [31:0]          quo  [N];
  baro_pkg::baro_side_t side [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0]          rem_in, num_in, den_in, quo_in;
    baro_pkg::baro_side_t side_in;
    logic                 v_in;
    logic [32:0]          trial, diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = in_data.num;
      assign den_in  = in_data.den;
      assign quo_in  = '0;
      assign side_in = in_data.side;
      assign v_in    = in_vld;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign num_in  = nrm[k-1];
      assign den_in  = den[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
      assign v_in    = vld[k-1];
    end

    assign trial = {rem_in, num_in[31]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= diff[32] ? trial[31:0] : diff[31:0];
        nrm[k]  <= num_in << 1;
        den[k]  <= den_in;
        quo[k]  <= {quo_in[30:0], ~diff[32]};
        side[k] <= side_in;
      end
    end
  end

  assign out_vld       = vld[N-1];
  assign out_data.quo  = quo[N-1];
  assign out_data.side = side[N-1];

  `BARO_ASSERT_NOW(a_rem_below_den, vld[N-1] && !side[N-1].zero, rem[N-1] < den[N-1], "remainder not below divisor")

endmodule
`default_nettype wire

[rtl/baro_back.sv]
// pressure correction after the divide
`default_nettype none
module baro_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire baro_pkg::baro_div_out_t in_data,
  input  wire baro_pkg::baro_cal_t     cal,
  output logic                         out_vld,
  output logic [31:0]                  out_temp,
  output logic [31:0]                  out_press,
  output logic                         out_zero
);

  logic [2:0]  vld;
  logic [31:0] pa_a, temp_a;
  logic        zero_a;
  logic [31:0] pa_b, temp_b, ss_b, b0_b;
  logic        zero_b;
  logic [31:0] pa_c, temp_c, a_c, bb_c;
  logic        zero_c;
  logic [31:0] s_b;
  logic [31:0] corr;

  assign s_b = pa_a >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_a   <= in_data.side.dbl ? (in_data.quo << 1) : in_data.quo;
      temp_a <= in_data.side.temp;
      zero_a <= in_data.side.zero;

      ss_b   <= s_b * s_b;
      b0_b   <= (pa_a >> 2) * baro_pkg::sx16(cal.p8);
      pa_b   <= pa_a;
      temp_b <= temp_a;
      zero_b <= zero_a;

      a_c    <= baro_pkg::asr32(baro_pkg::sx16(cal.p9) * (ss_b >> 13), 12);
      bb_c   <= baro_pkg::asr32(b0_b, 13);
      pa_c   <= pa_b;
      temp_c <= temp_b;
      zero_c <= zero_b;
    end
  end

  assign corr      = baro_pkg::asr32(a_c + bb_c + baro_pkg::sx16(cal.p7), 4);
  assign out_vld   = vld[2];
  assign out_temp  = temp_c;
  assign out_press = zero_c ? 32'd0 : (pa_c + corr);
  assign out_zero  = zero_c;

endmodule
`default_nettype wire

[rtl/baro_temp_compensation_top.sv]
// top level of the barometric temperature and pressure compensation block
//
// channel  signals                                           direction
// in       in_valid/in_ready, raw_temperature, raw_pressure  beat in
// out      out_valid/out_ready, temperature_centi,
//          pressure_pa, pressure_invalid                     beat out
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data          write beat in
//
// one beat per cycle unless the output is held; 11 front stages, 32 divider stages
// (one quotient bit each), 3 correction stages and the output register
// rst clears all valid bits and the calibration registers
// a held output stalls the whole pipeline; in_ready falls only then
// cfg_ready is always high
`default_nettype none
`include "baro_temp_compensation_top_assert.svh"
module baro_temp_compensation_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [19:0]        raw_temperature,
  input  wire logic [19:0]        raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      temperature_centi,
  output logic [31:0]             pressure_pa,
  output logic                    pressure_invalid,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);

  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  baro_pkg::baro_cal_t     cal;
  logic                    en;
  logic                    front_vld, div_vld, back_vld;
  baro_pkg::baro_div_in_t  front_data;
  baro_pkg::baro_div_out_t div_data;
  logic [31:0]             back_temp, back_press;
  logic                    back_zero;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
    end else if (cfg_valid) begin
      case (baro_pkg::baro_reg_t'(cfg_index))
        baro_pkg::REG_TEMP_CAL:    temp_cal    <= cfg_data;
        baro_pkg::REG_PRESS_CAL_A: press_cal_a <= cfg_data;
        baro_pkg::REG_PRESS_CAL_B: press_cal_b <= cfg_data;
        baro_pkg::REG_PRESS_CAL_C: press_cal_c <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal[15:0];
    cal.t2 = temp_cal[31:16];
    cal.t3 = temp_cal[47:32];
    cal.p1 = press_cal_a[15:0];
    cal.p2 = press_cal_a[31:16];
    cal.p3 = press_cal_a[47:32];
    cal.p4 = press_cal_b[15:0];
    cal.p5 = press_cal_b[31:16];
    cal.p6 = press_cal_b[47:32];
    cal.p7 = press_cal_c[15:0];
    cal.p8 = press_cal_c[31:16];
    cal.p9 = press_cal_c[47:32];
  end

  baro_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_beat  (in_valid && in_ready),
    .raw_t    (raw_temperature),
    .raw_p    (raw_pressure),
    .cal      (cal),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  baro_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (div_vld),
    .out_data (div_data)
  );

  baro_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (div_vld),
    .in_data   (div_data),
    .cal       (cal),
    .out_vld   (back_vld),
    .out_temp  (back_temp),
    .out_press (back_press),
    .out_zero  (back_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= back_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_centi <= $signed(back_temp);
      pressure_pa       <= back_press;
      pressure_invalid  <= back_zero;
    end
  end

  `BARO_ASSERT_NOW(a_invalid_zero, out_valid && pressure_invalid, pressure_pa == 32'd0, "invalid pressure not zero")
  `BARO_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without held output")

endmodule
`default_nettype wire

[test/testbench.sv]
// testbench for the barometric temperature and pressure compensation block
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic        pressure_invalid;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_pa;
  logic pressure_invalid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  baro_pkg::baro_reg_t cfg_index = baro_pkg::REG_TEMP_CAL;
  logic [47:0] cfg_data = '0;

  logic [47:0] cal_regs [4];
  reading_t expected_readings [$];
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned cycle_count = 0;
  bit stall_free = 1'b0;

  baro_temp_compensation_top u_dut (
    .clk, .rst, .in_valid, .in_ready, .raw_temperature, .raw_pressure,
    .out_valid, .out_ready, .temperature_centi, .pressure_pa, .pressure_invalid,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] cal_word(input int r, input int slot, input bit sgn);
    logic [15:0] w;
    w = cal_regs[r][16*slot +: 16];
    return sgn ? {{16{w[15]}}, w} : {16'd0, w};
  endfunction

  function automatic reading_t compensate(input logic [19:0] ut20, input logic [19:0] up20);
    reading_t res;
    logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] x1, x2, d, fine, q, a, b, p;
    ut = {12'd0, ut20};
    up = {12'd0, up20};
    t1 = cal_word(0, 0, 1'b0); t2 = cal_word(0, 1, 1'b1); t3 = cal_word(0, 2, 1'b1);
    p1 = cal_word(1, 0, 1'b0); p2 = cal_word(1, 1, 1'b1); p3 = cal_word(1, 2, 1'b1);
    p4 = cal_word(2, 0, 1'b1); p5 = cal_word(2, 1, 1'b1); p6 = cal_word(2, 2, 1'b1);
    p7 = cal_word(3, 0, 1'b1); p8 = cal_word(3, 1, 1'b1); p9 = cal_word(3, 2, 1'b1);
    x1 = sra(((ut >> 3) - (t1 << 1)) * t2, 11);
    d = (ut >> 4) - t1;
    x2 = sra(sra(d * d, 12) * t3, 14);
    fine = x1 + x2;
    res.temperature_centi = sra(fine * 32'd5 + 32'd128, 8);
    x1 = sra(fine, 1) - 32'd64000;
    q = sra(x1, 2);
    x2 = sra(q * q, 11) * p6;
    x2 = x2 + ((x1 * p5) << 1);
    x2 = sra(x2, 2) + (p4 << 16);
    x1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * x1, 1), 18);
    x1 = sra((32'd32768 + x1) * p1, 15);
    if (x1 == 0) begin
      res.pressure_pa = '0;
      res.pressure_invalid = 1'b1;
      return res;
    end
    p = ((32'd1048576 - up) - sra(x2, 12)) * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / x1;
    else p = (p / x1) * 32'd2;
    a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
    b = sra((p >> 2) * p8, 13);
    res.pressure_pa = p + sra(a + b + p7, 4);
    res.pressure_invalid = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at reading %0d: got %h want %h", what, readings_seen, got, want);
    mismatches++;
  endtask

  task automatic random_gap();
    int unsigned n;
    if (stall_free) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_sample(input logic [19:0] ut, input logic [19:0] up);
    if ($urandom_range(0, 2) == 0) random_gap();
    in_valid <= 1'b1;
    raw_temperature <= ut;
    raw_pressure <= up;
    expected_readings.push_back(compensate(ut, up));
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cal(input baro_pkg::baro_reg_t idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cal_regs[idx] = val;
  endtask

  task automatic end_cal();
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // plausible sensor trimming with random spread around it
  task automatic load_typical_cal();
    write_cal(baro_pkg::REG_TEMP_CAL, {16'($urandom_range(0, 200) - 100),
                                       16'(26000 + $urandom_range(0, 1000)),
                                       16'(27000 + $urandom_range(0, 1000))});
    write_cal(baro_pkg::REG_PRESS_CAL_A, {16'(-16'sd4096 + $urandom_range(0, 2000)),
                                          16'(-16'sd10600 + $urandom_range(0, 200)),
                                          16'(36000 + $urandom_range(0, 2000))});
    write_cal(baro_pkg::REG_PRESS_CAL_B, {16'(-16'sd7 + $urandom_range(0, 14)),
                                          16'($urandom_range(0, 300)),
                                          16'(2800 + $urandom_range(0, 400))});
    write_cal(baro_pkg::REG_PRESS_CAL_C, {16'(5000 + $urandom_range(0, 2000)),
                                          16'(-16'sd14600 + $urandom_range(0, 400)),
                                          16'($urandom_range(0, 30))});
    end_cal();
  endtask

  task automatic test_reset_calibration();
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_extremes();
    logic [19:0] edges [4] = '{20'd0, 20'd1, 20'h80000, 20'hFFFFF};
    load_typical_cal();
    foreach (edges[i]) foreach (edges[j]) send_sample(edges[i], edges[j]);
    send_sample(20'd519888, 20'd415148);
    drain();
    write_cal(baro_pkg::REG_TEMP_CAL, 48'hFFFF_FFFF_FFFF);
    write_cal(baro_pkg::REG_PRESS_CAL_A, 48'h7FFF_8000_FFFF);
    write_cal(baro_pkg::REG_PRESS_CAL_B, 48'h8000_7FFF_8000);
    write_cal(baro_pkg::REG_PRESS_CAL_C, 48'h7FFF_8000_7FFF);
    end_cal();
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();
    // p1 zero gives the divisor-zero case
    write_cal(baro_pkg::REG_PRESS_CAL_A, 48'h1234_5678_0000);
    end_cal();
    send_sample(20'd500000, 20'd400000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_random_typical(input int n);
    load_typical_cal();
    for (int i = 0; i < n; i++) begin
      send_sample(20'(400000 + $urandom_range(0, 250000)),
                  20'(250000 + $urandom_range(0, 300000)));
      if (i == n / 2) begin
        drain();
        stall_free = 1'b1;
        for (int k = 0; k < 60; k++) send_sample(20'($urandom()), 20'($urandom()));
        stall_free = 1'b0;
      end
    end
    drain();
  endtask

  task automatic test_random_wild(input int n);
    write_cal(baro_pkg::REG_TEMP_CAL, rand48());
    write_cal(baro_pkg::REG_PRESS_CAL_A,
              $urandom_range(0, 3) == 0 ? {rand48()} & 48'hFFFF_FFFF_0000 : rand48());
    write_cal(baro_pkg::REG_PRESS_CAL_B, rand48());
    write_cal(baro_pkg::REG_PRESS_CAL_C, rand48());
    end_cal();
    for (int i = 0; i < n; i++) send_sample(20'($urandom()), 20'($urandom()));
    drain();
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (stall_free || $urandom_range(0, 3) != 0) out_ready <= 1'b1;
      else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk);
        out_ready <= 1'b1;
      end else out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected beat", pressure_pa, 32'd0);
      end else begin
        want = expected_readings.pop_front();
        if (temperature_centi !== want.temperature_centi)
          report_mismatch("temperature_centi", temperature_centi, want.temperature_centi);
        if (pressure_pa !== want.pressure_pa)
          report_mismatch("pressure_pa", pressure_pa, want.pressure_pa);
        if (pressure_invalid !== want.pressure_invalid)
          report_mismatch("pressure_invalid", {31'd0, pressure_invalid},
                          {31'd0, want.pressure_invalid});
        if (want.pressure_invalid) invalid_seen++;
      end
      readings_seen++;
    end
  end

  initial begin
    foreach (cal_regs[i]) cal_regs[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calibration();
    test_extremes();
    test_random_typical(700);
    for (int r = 0; r < 8; r++) test_random_wild(70);
    test_random_typical(300);
    drain();
    $display("sent %0d samples, checked %0d readings, %0d with zero divisor",
             samples_sent, readings_seen, invalid_seen);
    $display("covered reset, extreme and random calibrations with random stalls");
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
